// File: design/depression_fill_cell_update_unit_defines.svh
// assertion macros for the checker in dfcu_checker.sv
`ifndef DEPRESSION_FILL_CELL_UPDATE_UNIT_DEFINES_SVH
`define DEPRESSION_FILL_CELL_UPDATE_UNIT_DEFINES_SVH

// checked outside reset only
`define DFCU_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("dfcu assertion failed");

// checked on every edge, reset included
`define DFCU_ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("dfcu assertion failed");

`endif

// File: design/dfcu_pkg.sv
`default_nettype none

package dfcu_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned LIM_W          = DATA_W + 1;
  localparam int unsigned GAP_W          = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned WINDOW_RADIUS  = 1;
  localparam int unsigned WIN_SIDE       = 2 * WINDOW_RADIUS + 1;
  localparam int unsigned NUM_NBR        = WIN_SIDE * WIN_SIDE - 1;

  localparam logic signed [DATA_W-1:0] NO_DATA_RST    = -32'sd99990000;
  localparam logic        [GAP_W-1:0]  FILL_GAP_RST   = 16'd5;
  localparam logic signed [DATA_W-1:0] FILL_START_RST = 32'sd100000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NO_DATA    = 2'd0,
    REG_FILL_GAP   = 2'd1,
    REG_FILL_START = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] ground_level;
    logic signed [DATA_W-1:0] prior_fill;
    logic signed [DATA_W-1:0] win_nw;
    logic signed [DATA_W-1:0] win_n;
    logic signed [DATA_W-1:0] win_ne;
    logic signed [DATA_W-1:0] win_w;
    logic signed [DATA_W-1:0] win_center;
    logic signed [DATA_W-1:0] win_e;
    logic signed [DATA_W-1:0] win_sw;
    logic signed [DATA_W-1:0] win_s;
    logic signed [DATA_W-1:0] win_se;
  } dfcu_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_surface;
    logic signed [DATA_W-1:0] new_ground;
    logic                     changed;
  } dfcu_out_t;

  // lane results of one item, handed to the merge
  typedef struct packed {
    logic                              pass;
    logic signed [DATA_W-1:0]          base_surface;
    logic signed [DATA_W-1:0]          ground;
    logic signed [DATA_W-1:0]          new_ground;
    logic        [NUM_NBR-1:0][LIM_W-1:0] lim;
    logic        [NUM_NBR-1:0]         drop;
  } dfcu_lanes_t;

endpackage

`default_nettype wire

// File: design/dfcu_lane.sv
`default_nettype none

module dfcu_lane (
  input  logic signed [dfcu_pkg::DATA_W-1:0] nbr_i,
  input  logic signed [dfcu_pkg::DATA_W-1:0] ground_i,
  input  logic signed [dfcu_pkg::DATA_W-1:0] nd_i,
  input  logic        [dfcu_pkg::GAP_W-1:0]  gap_i,
  output logic signed [dfcu_pkg::LIM_W-1:0]  lim_o,
  output logic                               drop_o
);

  logic signed [dfcu_pkg::LIM_W-1:0] ground_ext;

  // neighbour plus gap, one bit wider so it never wraps
  assign lim_o = $signed({nbr_i[dfcu_pkg::DATA_W-1], nbr_i})
               + $signed({{(dfcu_pkg::LIM_W - dfcu_pkg::GAP_W){1'b0}}, gap_i});
  assign ground_ext = $signed({ground_i[dfcu_pkg::DATA_W-1], ground_i});
  assign drop_o = (ground_ext >= lim_o) || (nbr_i == nd_i);

endmodule

`default_nettype wire

// File: design/dfcu_merge.sv
`default_nettype none

module dfcu_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              lanes_valid_i,
  input  dfcu_pkg::dfcu_lanes_t             lanes_i,
  output logic                              lanes_rdy_o,
  input  logic signed [dfcu_pkg::DATA_W-1:0] nd_i,
  output logic                              res_valid_o,
  output dfcu_pkg::dfcu_out_t               res_o,
  input  logic                              res_rdy_i
);

  function automatic logic signed [dfcu_pkg::LIM_W-1:0] min33(
    input logic signed [dfcu_pkg::LIM_W-1:0] a,
    input logic signed [dfcu_pkg::LIM_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  typedef struct packed {
    logic                               pass;
    logic signed [dfcu_pkg::DATA_W-1:0] base_surface;
    logic signed [dfcu_pkg::DATA_W-1:0] ground;
    logic signed [dfcu_pkg::DATA_W-1:0] new_ground;
    logic signed [dfcu_pkg::LIM_W-1:0]  min_a;
    logic signed [dfcu_pkg::LIM_W-1:0]  min_b;
    logic                               drop_a;
  } part_t;

  logic  s2_valid_q;
  part_t s2_d, s2_q;

  logic signed [dfcu_pkg::LIM_W-1:0] base_ext, m01, m23, m45, m67;
  logic signed [dfcu_pkg::LIM_W-1:0] fmin, nd_ext, s2_base_ext;
  logic                              center_drop, drop;

  // first half of the window, centre excluded, together with the cell surface
  assign base_ext = $signed({lanes_i.base_surface[dfcu_pkg::DATA_W-1], lanes_i.base_surface});
  assign m01 = min33($signed(lanes_i.lim[0]), $signed(lanes_i.lim[1]));
  assign m23 = min33($signed(lanes_i.lim[2]), $signed(lanes_i.lim[3]));
  assign m45 = min33($signed(lanes_i.lim[4]), $signed(lanes_i.lim[5]));
  assign m67 = min33($signed(lanes_i.lim[6]), $signed(lanes_i.lim[7]));

  always_comb begin
    s2_d.pass         = lanes_i.pass;
    s2_d.base_surface = lanes_i.base_surface;
    s2_d.ground       = lanes_i.ground;
    s2_d.new_ground   = lanes_i.new_ground;
    s2_d.min_a        = min33(base_ext, min33(m01, m23));
    s2_d.min_b        = min33(m45, m67);
    s2_d.drop_a       = |lanes_i.drop;
  end

  assign lanes_rdy_o = !s2_valid_q || res_rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (lanes_rdy_o) begin
      s2_valid_q <= lanes_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lanes_rdy_o && lanes_valid_i) begin
      s2_q <= s2_d;
    end
  end

  // the centre entry sees the running surface: no-data there drops to ground
  assign nd_ext      = $signed({nd_i[dfcu_pkg::DATA_W-1], nd_i});
  assign s2_base_ext = $signed({s2_q.base_surface[dfcu_pkg::DATA_W-1], s2_q.base_surface});
  assign center_drop = (s2_q.min_a == nd_ext);
  assign drop        = s2_q.drop_a || center_drop;
  assign fmin        = min33(s2_q.min_a, s2_q.min_b);

  always_comb begin
    res_o.new_ground = s2_q.new_ground;
    if (s2_q.pass) begin
      res_o.new_surface = s2_q.base_surface;
      res_o.changed     = 1'b0;
    end else if (drop) begin
      res_o.new_surface = s2_q.ground;
      res_o.changed     = 1'b1;
    end else begin
      res_o.new_surface = fmin[dfcu_pkg::DATA_W-1:0];
      res_o.changed     = (fmin < s2_base_ext);
    end
  end

  assign res_valid_o = s2_valid_q;

endmodule

`default_nettype wire

// File: design/depression_fill_cell_update_unit.sv
// depression fill cell update unit
// one cell step of pit filling; the input item carries the pass selector, the
// cell ground, the prior fill and the 3x3 water-surface window
// channels: in_valid_i / in_stall_o / in_item_i and out_valid_o / out_stall_i /
// out_item_o; an item moves at an edge where valid is high and stall is low
// one result item per input item, in order
// on the input accept edge the item loads the lane stage, then the merge stage
// and the output register take it in turn, and out_valid_o rises with the latter
// throughput: one item per cycle while out_stall_i is low; the eight neighbour
// lanes and the min tree of the merge are fully pipelined
// configuration (0 no-data code, 1 fill gap, 2 fill start): cfg_we_i writes
// cfg_wdata_i at cfg_idx_i; write only while the unit is idle (unchecked)
// reset: pipeline empties and registers take their reset values
// receiver stall: the output item holds; the stages behind keep filling, and
// in_stall_o rises once all three hold an item
`default_nettype none

module depression_fill_cell_update_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dfcu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dfcu_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dfcu_pkg::dfcu_in_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dfcu_pkg::dfcu_out_t                 out_item_o
);

  logic signed [dfcu_pkg::DATA_W-1:0] nd_q, start_q;
  logic        [dfcu_pkg::GAP_W-1:0]  gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q    <= dfcu_pkg::NO_DATA_RST;
      gap_q   <= dfcu_pkg::FILL_GAP_RST;
      start_q <= dfcu_pkg::FILL_START_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfcu_pkg::REG_NO_DATA:    nd_q    <= cfg_wdata_i;
        dfcu_pkg::REG_FILL_GAP:   gap_q   <= cfg_wdata_i[dfcu_pkg::GAP_W-1:0];
        dfcu_pkg::REG_FILL_START: start_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // neighbours in row order, centre left out
  logic signed [dfcu_pkg::DATA_W-1:0] nbr [dfcu_pkg::NUM_NBR];
  logic signed [dfcu_pkg::LIM_W-1:0]  lane_lim [dfcu_pkg::NUM_NBR];
  logic        [dfcu_pkg::NUM_NBR-1:0] lane_drop;

  assign nbr[0] = in_item_i.win_nw;
  assign nbr[1] = in_item_i.win_n;
  assign nbr[2] = in_item_i.win_ne;
  assign nbr[3] = in_item_i.win_w;
  assign nbr[4] = in_item_i.win_e;
  assign nbr[5] = in_item_i.win_sw;
  assign nbr[6] = in_item_i.win_s;
  assign nbr[7] = in_item_i.win_se;

  for (genvar k = 0; k < dfcu_pkg::NUM_NBR; k++) begin : g_lane
    dfcu_lane u_lane (
      .nbr_i    (nbr[k]),
      .ground_i (in_item_i.ground_level),
      .nd_i     (nd_q),
      .gap_i    (gap_q),
      .lim_o    (lane_lim[k]),
      .drop_o   (lane_drop[k])
    );
  end

  logic                  is_nd;
  logic                  s1_valid_q, s1_rdy, merge_rdy;
  dfcu_pkg::dfcu_lanes_t s1_d, s1_q;

  assign is_nd = (in_item_i.ground_level == nd_q);

  always_comb begin
    s1_d.ground = in_item_i.ground_level;
    s1_d.drop   = lane_drop;
    for (int k = 0; k < dfcu_pkg::NUM_NBR; k++) begin
      s1_d.lim[k] = lane_lim[k];
    end
    if (!in_item_i.func) begin
      s1_d.pass         = 1'b1;
      s1_d.base_surface = is_nd ? nd_q : start_q;
      s1_d.new_ground   = (!is_nd && (in_item_i.prior_fill > in_item_i.ground_level)) ?
                          in_item_i.prior_fill : in_item_i.ground_level;
    end else begin
      s1_d.pass         = is_nd || (in_item_i.win_center <= in_item_i.ground_level);
      s1_d.base_surface = in_item_i.win_center;
      s1_d.new_ground   = in_item_i.ground_level;
    end
  end

  assign s1_rdy     = !s1_valid_q || merge_rdy;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  logic                res_valid, out_rdy;
  dfcu_pkg::dfcu_out_t res;
  logic                out_valid_q;
  dfcu_pkg::dfcu_out_t out_q;

  assign out_rdy = !out_valid_q || !out_stall_i;

  dfcu_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lanes_valid_i (s1_valid_q),
    .lanes_i       (s1_q),
    .lanes_rdy_o   (merge_rdy),
    .nd_i          (nd_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_rdy_i     (out_rdy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: design/dfcu_checker.sv
`default_nettype none

`include "depression_fill_cell_update_unit_defines.svh"

module dfcu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dfcu_pkg::dfcu_out_t out_item_o
);

  // a stalled result item stays put
  `DFCU_ASSERT_RST(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))

  // the input side only backs up behind a stalled output
  `DFCU_ASSERT_RST(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

  // a lowered surface never goes below ground
  `DFCU_ASSERT_ANY(a_changed_above_ground, out_valid_o && out_item_o.changed |-> $signed(out_item_o.new_surface) >= $signed(out_item_o.new_ground))

  // the output is empty when reset is released
  `DFCU_ASSERT_RST(a_reset_empty, $rose(rst_ni) |-> !out_valid_o)

endmodule

bind depression_fill_cell_update_unit dfcu_checker u_dfcu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// File: verif/depression_fill_cell_update_unit_tb.sv
`timescale 1ns / 100ps

module depression_fill_cell_update_unit_tb;

  localparam logic signed [dfcu_pkg::DATA_W-1:0] LEVEL_MIN = 32'sh8000_0000;
  localparam logic signed [dfcu_pkg::DATA_W-1:0] LEVEL_MAX = 32'sh7fff_ffff;
  localparam int HOLD_CYCLES    = 160;
  localparam int TIMEOUT_CYCLES = 400000;

  class cell_scoreboard;
    logic signed [dfcu_pkg::DATA_W-1:0] no_data;
    logic        [dfcu_pkg::GAP_W-1:0]  gap;
    logic signed [dfcu_pkg::DATA_W-1:0] start;
    dfcu_pkg::dfcu_out_t                expected_q[$];
    int                                 errors;
    int                                 checked;

    function new();
      no_data = dfcu_pkg::NO_DATA_RST;
      gap     = dfcu_pkg::FILL_GAP_RST;
      start   = dfcu_pkg::FILL_START_RST;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(dfcu_pkg::cfg_reg_e idx, logic [dfcu_pkg::DATA_W-1:0] d);
      case (idx)
        dfcu_pkg::REG_NO_DATA:    no_data = d;
        dfcu_pkg::REG_FILL_GAP:   gap = d[dfcu_pkg::GAP_W-1:0];
        dfcu_pkg::REG_FILL_START: start = d;
        default: ;
      endcase
    endfunction

    function dfcu_pkg::dfcu_out_t fill_cell(dfcu_pkg::dfcu_in_t it);
      logic signed [dfcu_pkg::DATA_W-1:0] win [9];
      longint                             ground;
      longint                             surf;
      longint                             v;
      longint                             lim;
      dfcu_pkg::dfcu_out_t                res;
      win = '{it.win_nw, it.win_n, it.win_ne, it.win_w, it.win_center,
              it.win_e, it.win_sw, it.win_s, it.win_se};
      ground         = $signed(it.ground_level);
      surf           = $signed(it.win_center);
      res.new_ground = it.ground_level;
      res.changed    = 1'b0;
      if (!it.func) begin
        if (it.ground_level != no_data) begin
          surf = $signed(start);
          if ($signed(it.prior_fill) > $signed(it.ground_level)) begin
            res.new_ground = it.prior_fill;
          end
        end else begin
          surf = $signed(no_data);
        end
      end else if (it.ground_level != no_data && surf > ground) begin
        for (int k = 0; k < 9; k++) begin
          v   = (k == 4) ? surf : longint'($signed(win[k]));
          lim = v + longint'(gap);
          if (ground >= lim || v == longint'($signed(no_data))) begin
            surf        = ground;
            res.changed = 1'b1;
          end else if (surf > lim) begin
            surf        = lim;
            res.changed = 1'b1;
          end
        end
      end
      res.new_surface = surf[dfcu_pkg::DATA_W-1:0];
      return res;
    endfunction

    function void note_item(dfcu_pkg::dfcu_in_t it);
      expected_q.push_back(fill_cell(it));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(dfcu_pkg::dfcu_out_t got);
      dfcu_pkg::dfcu_out_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.new_surface !== exp.new_surface)
        report_mismatch($sformatf("new_surface %0d, want %0d", got.new_surface,
                                  exp.new_surface));
      if (got.new_ground !== exp.new_ground)
        report_mismatch($sformatf("new_ground %0d, want %0d", got.new_ground,
                                  exp.new_ground));
      if (got.changed !== exp.changed)
        report_mismatch($sformatf("changed %b, want %b", got.changed, exp.changed));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [dfcu_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [dfcu_pkg::DATA_W-1:0]    cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  dfcu_pkg::dfcu_in_t             in_item_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  dfcu_pkg::dfcu_out_t            out_item_o;

  cell_scoreboard sb = new();
  int  items_sent = 0;
  int  cycle_cnt;
  bit  idle_on    = 1'b1;
  int  stall_pct  = 30;
  bit  hold_req   = 1'b0;

  depression_fill_cell_update_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (cycle_cnt = 0; cycle_cnt < TIMEOUT_CYCLES; cycle_cnt++) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // receiver: random stall runs, and a long hold-off on request
  initial begin
    int run;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
        run = ($urandom_range(99) < 5) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [dfcu_pkg::DATA_W-1:0] near_level(
    logic signed [dfcu_pkg::DATA_W-1:0] base
  );
    int r;
    int span;
    r    = $urandom_range(99);
    span = int'(sb.gap) + 20;
    if (r < 5) return sb.no_data;
    if (r < 8) return LEVEL_MIN;
    if (r < 11) return LEVEL_MAX;
    if (r < 20) return $urandom();
    return 32'(longint'(base) + longint'($urandom_range(4 * span)) - span);
  endfunction

  function automatic dfcu_pkg::dfcu_in_t rand_cell();
    dfcu_pkg::dfcu_in_t                 c;
    logic signed [dfcu_pkg::DATA_W-1:0] g;
    int                                 r;
    r = $urandom_range(99);
    if (r < 5) g = sb.no_data;
    else if (r < 12) g = $urandom();
    else if (r < 14) g = LEVEL_MIN;
    else if (r < 16) g = LEVEL_MAX;
    else g = $urandom_range(2000000) - 1000000;
    c.func         = ($urandom_range(99) < 70);
    c.ground_level = g;
    c.prior_fill   = near_level(g);
    if (c.func && $urandom_range(99) < 80) begin
      c.win_center = ($urandom_range(99) < 20) ? sb.start :
                     32'(longint'(g) + $urandom_range(1, 4 * int'(sb.gap) + 100));
    end else begin
      c.win_center = near_level(g);
    end
    c.win_nw = near_level(g);
    c.win_n  = near_level(g);
    c.win_ne = near_level(g);
    c.win_w  = near_level(g);
    c.win_e  = near_level(g);
    c.win_sw = near_level(g);
    c.win_s  = near_level(g);
    c.win_se = near_level(g);
    return c;
  endfunction

  function automatic dfcu_pkg::dfcu_in_t make_cell(logic f,
                                                   logic signed [dfcu_pkg::DATA_W-1:0] g,
                                                   logic signed [dfcu_pkg::DATA_W-1:0] p,
                                                   logic signed [dfcu_pkg::DATA_W-1:0] ctr,
                                                   logic signed [dfcu_pkg::DATA_W-1:0] nbr);
    dfcu_pkg::dfcu_in_t c;
    c.func         = f;
    c.ground_level = g;
    c.prior_fill   = p;
    c.win_center   = ctr;
    c.win_nw       = nbr;
    c.win_n        = nbr;
    c.win_ne       = nbr;
    c.win_w        = nbr;
    c.win_e        = nbr;
    c.win_sw       = nbr;
    c.win_s        = nbr;
    c.win_se       = nbr;
    return c;
  endfunction

  task automatic send(dfcu_pkg::dfcu_in_t it, int gap);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.checked != items_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_cells(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) drain();
      send(rand_cell(), idle_gap());
    end
  endtask

  task automatic write_reg(dfcu_pkg::cfg_reg_e idx, logic [dfcu_pkg::DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task automatic set_config(logic [dfcu_pkg::DATA_W-1:0] nd,
                            logic [dfcu_pkg::DATA_W-1:0] gap_word,
                            logic [dfcu_pkg::DATA_W-1:0] st);
    write_reg(dfcu_pkg::REG_NO_DATA, nd);
    write_reg(dfcu_pkg::REG_FILL_GAP, gap_word);
    write_reg(dfcu_pkg::REG_FILL_START, st);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    dfcu_pkg::dfcu_in_t d;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // init pass
    send(make_cell(1'b0, 100, 500, 7, 7), 0);
    send(make_cell(1'b0, 100, -5, 7, 7), 1);
    send(make_cell(1'b0, sb.no_data, 7, 3, 3), 0);
    send(make_cell(1'b0, LEVEL_MIN, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX), 0);
    send(make_cell(1'b0, LEVEL_MAX, LEVEL_MIN, LEVEL_MIN, LEVEL_MIN), 2);
    // relax skips
    send(make_cell(1'b1, sb.no_data, 0, 1000, 0), 0);
    send(make_cell(1'b1, 50, 0, 50, 0), 0);
    send(make_cell(1'b1, 50, 0, LEVEL_MIN, 0), 0);
    // neighbour without data
    d = make_cell(1'b1, 0, 0, 1000, 1000); d.win_nw = sb.no_data; send(d, 0);
    // ground at neighbour plus gap, then a neighbour that lowers the surface
    d = make_cell(1'b1, 100, 0, 1000, 1000); d.win_se = 95; send(d, 0);
    d = make_cell(1'b1, 0, 0, 1000, 1000); d.win_e = 200; send(d, 3);
    // nothing fires
    send(make_cell(1'b1, 0, 0, 10, 10), 0);
    // centre itself without data
    send(make_cell(1'b1, sb.no_data - 1, 0, sb.no_data, LEVEL_MAX), 0);
    send(make_cell(1'b1, LEVEL_MIN, 0, LEVEL_MAX, LEVEL_MAX), 0);
    send(make_cell(1'b1, LEVEL_MIN, 0, LEVEL_MAX, LEVEL_MIN), 0);
    send(make_cell(1'b1, LEVEL_MAX - 1, LEVEL_MIN, LEVEL_MAX, LEVEL_MAX), 0);
    // rule order along the window
    d = make_cell(1'b1, 0, 0, 1000, 1000);
    d.win_nw = 300; d.win_n = 100; d.win_ne = -10; d.win_s = 2;
    send(d, 0);
    send(rand_cell(), 0);
    run_cells(300);
    drain();

    set_config(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff);
    send(make_cell(1'b1, 0, 0, 10, 10), 0);
    send(make_cell(1'b1, LEVEL_MIN + 1, 0, LEVEL_MAX, LEVEL_MIN), 0);
    send(make_cell(1'b0, LEVEL_MIN, 5, 5, 5), 0);
    run_cells(300);
    drain();

    set_config(32'h7fff_ffff, 32'h0000_ffff, 32'h8000_0000);
    send(make_cell(1'b1, LEVEL_MIN, 0, LEVEL_MAX - 1, LEVEL_MAX), 0);
    send(make_cell(1'b1, LEVEL_MAX, 0, LEVEL_MIN, LEVEL_MAX), 0);
    send(make_cell(1'b0, 0, 1, 1, 1), 0);
    run_cells(300);
    drain();

    // gap word carries random upper bits
    set_config($urandom(), $urandom(), $urandom());
    hold_req = 1'b1;
    repeat (40) send(rand_cell(), 0);
    run_cells(300);
    drain();

    set_config(32'h0000_0000, 32'h0000_0005, 32'h0000_0000);
    idle_on   = 1'b0;
    stall_pct = 0;
    run_cells(120);
    idle_on   = 1'b1;
    stall_pct = 50;
    run_cells(200);
    drain();

    repeat (10) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.report_mismatch("results missing at end");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
